/* hw/rtl/lattice_two_species_mc_step_defines.svh */
// assertion macros for the lattice two-species step block
`ifndef LATTICE_TWO_SPECIES_MC_STEP_DEFINES_SVH
`define LATTICE_TWO_SPECIES_MC_STEP_DEFINES_SVH

// same-cycle implication
`define LTSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ltsm_pkg.sv */
// shared types and constants for the lattice two-species step block
package ltsm_pkg;

  localparam int unsigned COORD_W = 7;
  localparam int unsigned ADDR_W  = 2 * COORD_W;
  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam int unsigned RAND_W  = 16;
  localparam int unsigned PROB_W  = 17;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [KIND_W-1:0] K_EMPTY    = 3'd0;
  localparam logic [KIND_W-1:0] K_NUTRIENT = 3'd1;
  localparam logic [KIND_W-1:0] K_SOIL     = 3'd2;
  localparam logic [KIND_W-1:0] K_GREEN    = 3'd3;
  localparam logic [KIND_W-1:0] K_BLUE     = 3'd4;

  localparam logic [2:0] OC_NONE     = 3'd0;
  localparam logic [2:0] OC_FILL     = 3'd1;
  localparam logic [2:0] OC_DEATH    = 3'd2;
  localparam logic [2:0] OC_MOVE     = 3'd3;
  localparam logic [2:0] OC_REPRO    = 3'd4;
  localparam logic [2:0] OC_NUTRIENT = 3'd5;
  localparam logic [2:0] OC_KEPT     = 3'd6;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SOIL_FILL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_REPRO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_REPRO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_NUTR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_NUTR  = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               axis;
    logic               direction;
    logic [RAND_W-1:0]  rand_first;
    logic [RAND_W-1:0]  rand_second;
    logic [KIND_W-1:0]  write_value;
  } in_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [KIND_W-1:0] read_value;
  } out_t;

  typedef struct packed {
    logic [PROB_W-1:0] soil_fill;
    logic [PROB_W-1:0] death;
    logic [PROB_W-1:0] green_repro;
    logic [PROB_W-1:0] blue_repro;
    logic [PROB_W-1:0] green_nutrient;
    logic [PROB_W-1:0] blue_nutrient;
  } prob_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [KIND_W-1:0] read_value;
    logic              site_we;
    logic [KIND_W-1:0] site_val;
    logic              nb_we;
    logic [KIND_W-1:0] nb_val;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_WR2  = 2'd2
  } state_t;

  function automatic logic chance(input logic [RAND_W-1:0] r, input logic [PROB_W-1:0] p);
    chance = {1'b0, r} < p;
  endfunction

endpackage

/* hw/rtl/ltsm_cfg.sv */
// probability configuration registers
module ltsm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ltsm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ltsm_pkg::PROB_W-1:0]      wr_data,
  output ltsm_pkg::prob_t                  probs
);

  ltsm_pkg::prob_t probs_r;
  ltsm_pkg::prob_t probs_nxt;

  always_comb begin
    probs_nxt = probs_r;
    if (wr_en) begin
      case (wr_index)
        ltsm_pkg::REG_SOIL_FILL:   probs_nxt.soil_fill      = wr_data;
        ltsm_pkg::REG_DEATH:       probs_nxt.death          = wr_data;
        ltsm_pkg::REG_GREEN_REPRO: probs_nxt.green_repro    = wr_data;
        ltsm_pkg::REG_BLUE_REPRO:  probs_nxt.blue_repro     = wr_data;
        ltsm_pkg::REG_GREEN_NUTR:  probs_nxt.green_nutrient = wr_data;
        ltsm_pkg::REG_BLUE_NUTR:   probs_nxt.blue_nutrient  = wr_data;
        default:                   probs_nxt = probs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probs_r.soil_fill      <= 17'd65536;
      probs_r.death          <= 17'd6554;
      probs_r.green_repro    <= 17'd16384;
      probs_r.blue_repro     <= 17'd32768;
      probs_r.green_nutrient <= 17'd65536;
      probs_r.blue_nutrient  <= 17'd0;
    end else begin
      probs_r <= probs_nxt;
    end
  end

  assign probs = probs_r;

endmodule

/* hw/rtl/ltsm_rule.sv */
// update rule: decides outcome and cell writes from site and neighbour kinds
module ltsm_rule (
  input  logic [1:0]                    cmd,
  input  logic [ltsm_pkg::KIND_W-1:0]   here,
  input  logic [ltsm_pkg::KIND_W-1:0]   nv,
  input  logic [ltsm_pkg::RAND_W-1:0]   rand_first,
  input  logic [ltsm_pkg::RAND_W-1:0]   rand_second,
  input  logic [ltsm_pkg::KIND_W-1:0]   write_value,
  input  ltsm_pkg::prob_t               probs,
  output ltsm_pkg::rule_t               res
);

  logic                           green;
  logic [ltsm_pkg::PROB_W-1:0]    repro_p;
  logic [ltsm_pkg::PROB_W-1:0]    nutr_p;

  assign green   = (here == ltsm_pkg::K_GREEN);
  assign repro_p = green ? probs.green_repro : probs.blue_repro;
  assign nutr_p  = green ? probs.green_nutrient : probs.blue_nutrient;

  always_comb begin
    res            = '0;
    res.outcome    = ltsm_pkg::OC_NONE;
    res.read_value = here;
    case (cmd)
      ltsm_pkg::CMD_WRITE: begin
        res.site_we  = 1'b1;
        res.site_val = write_value;
      end
      ltsm_pkg::CMD_READ: begin
        res.site_we = 1'b0;
      end
      ltsm_pkg::CMD_UPDATE: begin
        if (here inside {ltsm_pkg::K_EMPTY, ltsm_pkg::K_NUTRIENT}) begin
          if (nv == ltsm_pkg::K_SOIL && ltsm_pkg::chance(rand_first, probs.soil_fill)) begin
            res.site_we  = 1'b1;
            res.site_val = ltsm_pkg::K_SOIL;
            res.outcome  = ltsm_pkg::OC_FILL;
          end
        end else if (here inside {ltsm_pkg::K_GREEN, ltsm_pkg::K_BLUE}) begin
          res.site_we  = 1'b1;
          res.site_val = ltsm_pkg::K_EMPTY;
          if (ltsm_pkg::chance(rand_first, probs.death)) begin
            res.outcome = ltsm_pkg::OC_DEATH;
          end else begin
            res.nb_we   = 1'b1;
            res.nb_val  = here;
            res.outcome = ltsm_pkg::OC_MOVE;
            if (nv == ltsm_pkg::K_NUTRIENT) begin
              if (ltsm_pkg::chance(rand_second, repro_p)) begin
                res.site_val = here;
                res.outcome  = ltsm_pkg::OC_REPRO;
              end
            end else if (nv == ltsm_pkg::K_SOIL) begin
              if (ltsm_pkg::chance(rand_second, nutr_p)) begin
                res.site_val = ltsm_pkg::K_NUTRIENT;
                res.outcome  = ltsm_pkg::OC_NUTRIENT;
              end
            end else if (nv inside {ltsm_pkg::K_GREEN, ltsm_pkg::K_BLUE}) begin
              res.site_val = nv;
              res.outcome  = ltsm_pkg::OC_KEPT;
            end
          end
        end
      end
      default: begin
        res.read_value = ltsm_pkg::K_EMPTY;
      end
    endcase
  end

endmodule

/* hw/rtl/lattice_two_species_mc_step.sv */
// top level: lattice memory, command sequencer and result register
//
// Holds a periodic 128 x 128 lattice of 3-bit cells in one memory with two
// read ports and one write port. A command is taken when start is high and
// busy is low; in_item carries the command, the site, the neighbour choice,
// two random fractions and the value for a cell write.
// The accepting edge reads site and neighbour at once. In the next cycle the
// update rule runs and the site is written if the rule asks for it. A worm
// that moves then writes the neighbour in ST_WR2, as the memory has one write
// port. A command thus passes through ST_EXEC, and ST_WR2 when a worm moves,
// before the next is accepted; busy is high from the accepting edge until the
// last write is done. Each command gives one result: out_valid is registered
// from the ST_EXEC state and stays high for one cycle, with out_item valid in
// that cycle. The receiver cannot stall, so nothing is held back.
// Probabilities are to be written on the cfg channel (always ready) only while
// the block is idle; the block itself does not enforce this. Reset returns them
// to their defaults and the sequencer to idle.
// Lattice contents are undefined after reset until loaded by write commands.
`include "lattice_two_species_mc_step_defines.svh"

module lattice_two_species_mc_step (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ltsm_pkg::in_t                    in_item,
  output logic                             out_valid,
  output ltsm_pkg::out_t                   out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ltsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ltsm_pkg::PROB_W-1:0]      cfg_data
);

  logic [ltsm_pkg::KIND_W-1:0] mem [ltsm_pkg::DEPTH];

  ltsm_pkg::state_t            state_r;
  ltsm_pkg::state_t            state_nxt;
  ltsm_pkg::in_t               item_r;
  logic [ltsm_pkg::ADDR_W-1:0] nb_addr_r;
  logic [ltsm_pkg::KIND_W-1:0] nb_val_r;
  logic [ltsm_pkg::KIND_W-1:0] site_kind_r;
  logic [ltsm_pkg::KIND_W-1:0] nb_kind_r;
  logic                        out_valid_r;
  ltsm_pkg::out_t              out_item_r;

  logic                        accept;
  logic [ltsm_pkg::COORD_W-1:0] nb_row;
  logic [ltsm_pkg::COORD_W-1:0] nb_col;
  logic [ltsm_pkg::COORD_W-1:0] step;
  logic [ltsm_pkg::ADDR_W-1:0] site_addr_in;
  logic [ltsm_pkg::ADDR_W-1:0] nb_addr_in;
  logic [ltsm_pkg::ADDR_W-1:0] site_addr_r;
  logic                        mem_we;
  logic [ltsm_pkg::ADDR_W-1:0] mem_waddr;
  logic [ltsm_pkg::KIND_W-1:0] mem_wdata;
  ltsm_pkg::prob_t             probs;
  ltsm_pkg::rule_t             rule;

  assign busy      = (state_r != ltsm_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // neighbour address, wrapping on the 7-bit coordinate
  assign step         = in_item.direction ? 7'd1 : 7'h7f;
  assign nb_row       = in_item.axis ? in_item.row : in_item.row + step;
  assign nb_col       = in_item.axis ? in_item.col + step : in_item.col;
  assign site_addr_in = {in_item.row, in_item.col};
  assign nb_addr_in   = {nb_row, nb_col};
  assign site_addr_r  = {item_r.row, item_r.col};

  ltsm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .probs    (probs)
  );

  ltsm_rule u_rule (
    .cmd         (item_r.cmd),
    .here        (site_kind_r),
    .nv          (nb_kind_r),
    .rand_first  (item_r.rand_first),
    .rand_second (item_r.rand_second),
    .write_value (item_r.write_value),
    .probs       (probs),
    .res         (rule)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      site_kind_r <= mem[site_addr_in];
      nb_kind_r   <= mem[nb_addr_in];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = site_addr_r;
    mem_wdata = rule.site_val;
    case (state_r)
      ltsm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = ltsm_pkg::ST_EXEC;
        end
      end
      ltsm_pkg::ST_EXEC: begin
        mem_we    = rule.site_we;
        state_nxt = rule.nb_we ? ltsm_pkg::ST_WR2 : ltsm_pkg::ST_IDLE;
      end
      ltsm_pkg::ST_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr_r;
        mem_wdata = nb_val_r;
        state_nxt = ltsm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ltsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ltsm_pkg::ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_item;
      nb_addr_r <= nb_addr_in;
    end
    if (state_r == ltsm_pkg::ST_EXEC) begin
      nb_val_r           <= rule.nb_val;
      out_item_r.outcome    <= rule.outcome;
      out_item_r.read_value <= rule.read_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LTSM_ASSERT_IMPL(a_result_after_exec, out_valid_r, $past(state_r == ltsm_pkg::ST_EXEC), "result without execute cycle")
  `LTSM_ASSERT_IMPL(a_wr2_after_exec, state_r == ltsm_pkg::ST_WR2, $past(state_r == ltsm_pkg::ST_EXEC), "neighbour write out of sequence")
  `LTSM_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `LTSM_ASSERT_IMPL(a_nb_not_site, state_r == ltsm_pkg::ST_WR2, nb_addr_r != site_addr_r, "neighbour address equals site")

endmodule

/* verif/lattice_step_checker.sv */
// checker for the lattice step block: lattice and probability predictor and result compare
module lattice_step_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  ltsm_pkg::in_t                  in_item,
  input  logic                           out_valid,
  input  ltsm_pkg::out_t                 out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ltsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ltsm_pkg::PROB_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending,
  output logic [7:0]                     outcome_seen
);

  localparam int NUM_REGS = ltsm_pkg::REG_BLUE_NUTR + 1;

  typedef struct packed {
    ltsm_pkg::out_t value;
    logic           rv_known;
  } awaited_t;

  logic [ltsm_pkg::KIND_W-1:0] cells [ltsm_pkg::DEPTH];
  bit                          known [ltsm_pkg::DEPTH];
  logic [ltsm_pkg::PROB_W-1:0] prob [NUM_REGS];
  awaited_t                    awaited_results [$];
  int                          errors = 0;
  logic [7:0]                  seen = '0;

  function automatic bit hits(input logic [ltsm_pkg::RAND_W-1:0] draw,
                              input logic [ltsm_pkg::PROB_W-1:0] p);
    return 32'(draw) < 32'(p);
  endfunction

  task automatic apply_command(input ltsm_pkg::in_t it, output awaited_t exp);
    logic [ltsm_pkg::ADDR_W-1:0]  site, nb_site;
    logic [ltsm_pkg::COORD_W-1:0] nr, nc;
    logic [ltsm_pkg::KIND_W-1:0]  here, nbv;
    logic                         green;
    site = {it.row, it.col};
    here = cells[site];
    exp.value.outcome = ltsm_pkg::OC_NONE;
    exp.value.read_value = here;
    exp.rv_known = known[site];
    nr = it.row;
    nc = it.col;
    if (it.axis) begin
      nc = it.direction ? it.col + 1'b1 : it.col - 1'b1;
    end else begin
      nr = it.direction ? it.row + 1'b1 : it.row - 1'b1;
    end
    nb_site = {nr, nc};
    nbv = cells[nb_site];
    case (it.cmd)
      ltsm_pkg::CMD_WRITE: begin
        cells[site] = it.write_value;
        known[site] = 1'b1;
      end
      ltsm_pkg::CMD_NONE: begin
        exp.value.read_value = '0;
        exp.rv_known = 1'b1;
      end
      ltsm_pkg::CMD_UPDATE: begin
        if (here == ltsm_pkg::K_EMPTY || here == ltsm_pkg::K_NUTRIENT) begin
          if (nbv == ltsm_pkg::K_SOIL &&
              hits(it.rand_first, prob[ltsm_pkg::REG_SOIL_FILL])) begin
            cells[site] = ltsm_pkg::K_SOIL;
            exp.value.outcome = ltsm_pkg::OC_FILL;
          end
        end else if (here == ltsm_pkg::K_GREEN || here == ltsm_pkg::K_BLUE) begin
          green = (here == ltsm_pkg::K_GREEN);
          if (hits(it.rand_first, prob[ltsm_pkg::REG_DEATH])) begin
            cells[site] = ltsm_pkg::K_EMPTY;
            exp.value.outcome = ltsm_pkg::OC_DEATH;
          end else begin
            cells[nb_site] = here;
            known[nb_site] = 1'b1;
            cells[site] = ltsm_pkg::K_EMPTY;
            exp.value.outcome = ltsm_pkg::OC_MOVE;
            if (nbv == ltsm_pkg::K_NUTRIENT) begin
              if (hits(it.rand_second, green ? prob[ltsm_pkg::REG_GREEN_REPRO]
                                             : prob[ltsm_pkg::REG_BLUE_REPRO])) begin
                cells[site] = here;
                exp.value.outcome = ltsm_pkg::OC_REPRO;
              end
            end else if (nbv == ltsm_pkg::K_SOIL) begin
              if (hits(it.rand_second, green ? prob[ltsm_pkg::REG_GREEN_NUTR]
                                             : prob[ltsm_pkg::REG_BLUE_NUTR])) begin
                cells[site] = ltsm_pkg::K_NUTRIENT;
                exp.value.outcome = ltsm_pkg::OC_NUTRIENT;
              end
            end else if (nbv == ltsm_pkg::K_GREEN || nbv == ltsm_pkg::K_BLUE) begin
              cells[site] = nbv;
              exp.value.outcome = ltsm_pkg::OC_KEPT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : track
    awaited_t head, next_exp;
    if (!rst_n) begin
      prob[ltsm_pkg::REG_SOIL_FILL]   = 17'd65536;
      prob[ltsm_pkg::REG_DEATH]       = 17'd6554;
      prob[ltsm_pkg::REG_GREEN_REPRO] = 17'd16384;
      prob[ltsm_pkg::REG_BLUE_REPRO]  = 17'd32768;
      prob[ltsm_pkg::REG_GREEN_NUTR]  = 17'd65536;
      prob[ltsm_pkg::REG_BLUE_NUTR]   = 17'd0;
      known = '{default: 1'b0};
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= ltsm_pkg::REG_BLUE_NUTR) begin
        prob[cfg_index] = cfg_data;
      end
      if (out_valid) begin
        if (!$isunknown(out_item.outcome)) begin
          seen[out_item.outcome] = 1'b1;
        end
        if (awaited_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          errors++;
        end else begin
          head = awaited_results.pop_front();
          if (out_item.outcome !== head.value.outcome) begin
            $error("outcome: expected %0d, got %0d", head.value.outcome, out_item.outcome);
            errors++;
          end
          if (head.rv_known && out_item.read_value !== head.value.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   head.value.read_value, out_item.read_value);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        apply_command(in_item, next_exp);
        awaited_results = {awaited_results, next_exp};
      end
    end
    pending <= awaited_results.size();
    fail_count <= errors;
    outcome_seen <= seen;
  end

endmodule

/* verif/tb_lattice_two_species_mc_step.sv */
// testbench top for the lattice step block: clock, reset, stimulus and verdict
module tb_lattice_two_species_mc_step;

  localparam int COORD_W   = ltsm_pkg::COORD_W;
  localparam int KIND_W    = ltsm_pkg::KIND_W;
  localparam int RAND_W    = ltsm_pkg::RAND_W;
  localparam int PROB_W    = ltsm_pkg::PROB_W;
  localparam int CFG_IDX_W = ltsm_pkg::CFG_IDX_W;

  localparam int PERIOD          = 8;
  localparam int SIDE            = 1 << COORD_W;
  localparam int ZONE_HALF       = 4;
  localparam int IDLE_PCT        = 17;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int STALL_LIMIT     = 1000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int NUM_IDX         = 1 << CFG_IDX_W;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;
  localparam logic [PROB_W-1:0] PROB_MAX = '1;
  localparam logic [KIND_W-1:0] K_UNUSED = ltsm_pkg::K_BLUE + 1'b1;
  localparam logic [KIND_W-1:0] K_TOP    = '1;
  localparam logic [RAND_W-1:0] DRAW_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ltsm_pkg::in_t        in_item;
  logic                 out_valid;
  ltsm_pkg::out_t       out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PROB_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  logic [7:0]           outcome_seen;

  int sent = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  lattice_two_species_mc_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lattice_step_checker lattice_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .outcome_seen (outcome_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL lattice_two_species_mc_step");
      $finish;
    end
  end

  // working window: rows and cols 124..127 and 0..3, a torus patch across the wrap
  function automatic logic [COORD_W-1:0] zone_coord(input int idx);
    return COORD_W'(idx < ZONE_HALF ? idx : SIDE - 2 * ZONE_HALF + idx);
  endfunction

  function automatic bit in_zone(input logic [COORD_W-1:0] c);
    return int'(c) < ZONE_HALF || int'(c) >= SIDE - ZONE_HALF;
  endfunction

  function automatic logic [RAND_W-1:0] random_draw();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return DRAW_MAX;
    return RAND_W'($urandom);
  endfunction

  function automatic ltsm_pkg::in_t random_cmd();
    ltsm_pkg::in_t      it;
    int                 roll;
    logic [COORD_W-1:0] along, nb;
    roll = $urandom_range(99);
    it.cmd = roll < 22 ? ltsm_pkg::CMD_WRITE :
             roll < 32 ? ltsm_pkg::CMD_READ :
             roll < 35 ? ltsm_pkg::CMD_NONE : ltsm_pkg::CMD_UPDATE;
    it.row = zone_coord($urandom_range(2 * ZONE_HALF - 1));
    it.col = zone_coord($urandom_range(2 * ZONE_HALF - 1));
    it.axis = 1'($urandom_range(1));
    it.direction = 1'($urandom_range(1));
    it.rand_first = random_draw();
    it.rand_second = random_draw();
    if (it.cmd != ltsm_pkg::CMD_WRITE) begin
      it.write_value = KIND_W'($urandom);
    end else if ($urandom_range(9) == 0) begin
      it.write_value = KIND_W'($urandom_range(K_TOP, K_UNUSED));
    end else begin
      it.write_value = KIND_W'($urandom_range(ltsm_pkg::K_BLUE));
    end
    // keep the neighbour inside the loaded window
    along = it.axis ? it.col : it.row;
    nb = it.direction ? along + 1'b1 : along - 1'b1;
    if (!in_zone(nb)) it.direction = ~it.direction;
    return it;
  endfunction

  task automatic send_cmd(input ltsm_pkg::in_t it);
    logic [63:0] noise;
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      noise = {$urandom, $urandom};
      start = 1'b0;
      in_item = noise[$bits(ltsm_pkg::in_t)-1:0];
      @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic put_cell(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                          input logic [KIND_W-1:0] kind);
    ltsm_pkg::in_t it;
    it = random_cmd();
    it.cmd = ltsm_pkg::CMD_WRITE;
    it.row = r;
    it.col = c;
    it.write_value = kind;
    send_cmd(it);
  endtask

  task automatic step_site(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                           input logic ax, input logic dir,
                           input logic [RAND_W-1:0] r1, input logic [RAND_W-1:0] r2);
    ltsm_pkg::in_t it;
    it = random_cmd();
    it.cmd = ltsm_pkg::CMD_UPDATE;
    it.row = r;
    it.col = c;
    it.axis = ax;
    it.direction = dir;
    it.rand_first = r1;
    it.rand_second = r2;
    send_cmd(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_probs(input int ph);
    logic [PROB_W-1:0] val;
    for (int i = 0; i < NUM_IDX; i++) begin
      case (ph)
        1: val = '0;
        2: val = (i == ltsm_pkg::REG_DEATH) ? '0 : PROB_ONE;
        3: val = PROB_MAX;
        4: val = (i == ltsm_pkg::REG_DEATH) ? PROB_W'($urandom_range(PROB_ONE / 2))
                                            : PROB_W'($urandom_range(PROB_ONE));
        default: val = (i == ltsm_pkg::REG_DEATH) ? PROB_W'($urandom_range(PROB_ONE / 4))
                                                  : PROB_W'($urandom);
      endcase
      // indexes past the last register only on one setting
      if (i <= ltsm_pkg::REG_BLUE_NUTR || ph == 4) write_reg(CFG_IDX_W'(i), val);
    end
  endtask

  task automatic random_phase();
    ltsm_pkg::in_t it;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      it = random_cmd();
      if ($urandom_range(99) < 15) begin
        // plant a worm and step it right away
        it.cmd = ltsm_pkg::CMD_WRITE;
        it.write_value = $urandom_range(1) ? ltsm_pkg::K_GREEN : ltsm_pkg::K_BLUE;
        send_cmd(it);
        it.cmd = ltsm_pkg::CMD_UPDATE;
        it.rand_first = random_draw();
        it.rand_second = random_draw();
      end
      send_cmd(it);
    end
  endtask

  initial begin
    ltsm_pkg::in_t it;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load the working window so no unwritten cell is ever read
    for (int r = 0; r < 2 * ZONE_HALF; r++) begin
      for (int c = 0; c < 2 * ZONE_HALF; c++) begin
        put_cell(zone_coord(r), zone_coord(c), KIND_W'($urandom_range(ltsm_pkg::K_BLUE)));
      end
    end

    // directed cases under reset probabilities
    put_cell(7'd0, 7'd0, ltsm_pkg::K_EMPTY);
    put_cell(7'd127, 7'd0, ltsm_pkg::K_SOIL);
    step_site(7'd0, 7'd0, 1'b0, 1'b0, '0, '0);
    put_cell(7'd0, 7'd127, ltsm_pkg::K_NUTRIENT);
    step_site(7'd0, 7'd127, 1'b1, 1'b1, DRAW_MAX, DRAW_MAX);
    put_cell(7'd1, 7'd0, ltsm_pkg::K_GREEN);
    step_site(7'd1, 7'd0, 1'b0, 1'b0, '0, DRAW_MAX);
    put_cell(7'd1, 7'd1, ltsm_pkg::K_GREEN);
    put_cell(7'd1, 7'd2, ltsm_pkg::K_NUTRIENT);
    step_site(7'd1, 7'd1, 1'b1, 1'b1, DRAW_MAX, '0);
    put_cell(7'd2, 7'd0, ltsm_pkg::K_BLUE);
    step_site(7'd2, 7'd0, 1'b0, 1'b0, DRAW_MAX, DRAW_MAX);
    put_cell(7'd3, 7'd0, ltsm_pkg::K_GREEN);
    put_cell(7'd3, 7'd1, ltsm_pkg::K_SOIL);
    step_site(7'd3, 7'd0, 1'b1, 1'b1, DRAW_MAX, DRAW_MAX);
    put_cell(7'd126, 7'd0, ltsm_pkg::K_BLUE);
    put_cell(7'd125, 7'd0, ltsm_pkg::K_GREEN);
    step_site(7'd126, 7'd0, 1'b0, 1'b0, DRAW_MAX, '0);
    put_cell(7'd124, 7'd127, K_UNUSED);
    put_cell(7'd124, 7'd126, ltsm_pkg::K_BLUE);
    step_site(7'd124, 7'd126, 1'b1, 1'b1, DRAW_MAX, DRAW_MAX);
    put_cell(7'd125, 7'd127, K_TOP);
    step_site(7'd125, 7'd127, 1'b0, 1'b1, '0, '0);
    it = random_cmd();
    it.cmd = ltsm_pkg::CMD_READ;
    it.row = 7'd124;
    it.col = 7'd127;
    send_cmd(it);
    it.cmd = ltsm_pkg::CMD_NONE;
    it.row = 7'd127;
    it.col = 7'd127;
    send_cmd(it);

    random_phase();
    for (int ph = 1; ph < PHASES; ph++) begin
      drain();
      set_probs(ph);
      no_gaps = (ph == 2);
      random_phase();
    end
    no_gaps = 1'b0;
    drain();

    $display("summary: %0d commands over %0d probability settings, window across the wrap",
             sent, PHASES);
    $display("summary: outcome codes observed %b (bit n for code n)", outcome_seen);
    if (fail_count == 0) begin
      $display("PASS lattice_two_species_mc_step");
    end else begin
      $display("FAIL lattice_two_species_mc_step");
    end
    $finish;
  end

endmodule
